// File: src/brf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brf_pkg
// shared types, constants and helpers for the brent root finder
// ----------------------------------------------------------------------------
package brf_pkg;

  localparam int MAX_ITER_DEF = 100;
  localparam logic [63:0] ZEPS2_Q64 = 64'd3689348815;
  localparam logic signed [63:0] Q_ONE = 64'sh0000_0001_0000_0000;
  localparam logic signed [63:0] S_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S_MIN = 64'sh8000_0000_0000_0000;
  localparam logic [62:0] TOL_RESET = 63'd4295;

  typedef enum logic [1:0] {
    ST_EVAL  = 2'd0,
    ST_ROOT  = 2'd1,
    ST_NOSGN = 2'd2,
    ST_LIMIT = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_LEFT  = 2'd1,
    PH_RIGHT = 2'd2,
    PH_ITER  = 2'd3
  } phase_t;

  // step sequencer states
  typedef enum logic [4:0] {
    S_IDLE, S_PRE, S_TOL, S_TOLW, S_CHK, S_S, S_SW, S_Q, S_QW, S_R, S_RW,
    S_T1, S_T1W, S_T2, S_T2W, S_T3, S_T3W, S_P, S_PW, S_Q1, S_Q1W, S_Q2, S_Q2W,
    S_M1, S_M1W, S_M2, S_M2W, S_M3, S_M3W, S_DIV, S_DIVW, S_FIN
  } seq_t;

  // shared unit operations
  typedef enum logic [1:0] {
    OP_MUL  = 2'd0,
    OP_DIV  = 2'd1,
    OP_ZMUL = 2'd2
  } op_t;

  typedef struct packed {
    logic        start;
    op_t         op;
    logic [63:0] x;
    logic [63:0] y;
  } unit_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] res;
  } unit_rsp_t;

  function automatic logic [63:0] mag(input logic [63:0] x);
    return x[63] ? (64'd0 - x) : x;
  endfunction

  function automatic logic [63:0] mk(input logic neg, input logic [63:0] m);
    if (neg) return m[63] ? S_MIN : (64'd0 - m);
    return m[63] ? S_MAX : m;
  endfunction

  function automatic logic [63:0] sadd(input logic [63:0] x, input logic [63:0] y);
    logic [63:0] s;
    s = x + y;
    if (!x[63] && !y[63] && s[63]) return S_MAX;
    if (x[63] && y[63] && !s[63]) return S_MIN;
    return s;
  endfunction

  function automatic logic [63:0] ssub(input logic [63:0] x, input logic [63:0] y);
    logic [63:0] s;
    s = x - y;
    if (!x[63] && y[63] && s[63]) return S_MAX;
    if (x[63] && !y[63] && !s[63]) return S_MIN;
    return s;
  endfunction

  function automatic logic [63:0] sabs(input logic [63:0] x);
    if (x == S_MIN) return S_MAX;
    return x[63] ? (64'd0 - x) : x;
  endfunction

  function automatic logic [63:0] sneg(input logic [63:0] x);
    if (x == S_MIN) return S_MAX;
    return 64'd0 - x;
  endfunction

endpackage

// File: src/brf_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brf_unit
// shared iterative multiplier / divider, one bit per cycle
// ----------------------------------------------------------------------------
module brf_unit import brf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  unit_req_t req,
  output unit_rsp_t rsp
);

  logic        busy;
  op_t         op;
  logic        neg;
  logic [6:0]  cnt;
  logic [63:0] d;
  logic [63:0] rem;
  logic [63:0] lo;
  logic [63:0] q;
  logic [127:0] acc;
  logic [127:0] mcand;
  logic [63:0] mplier;

  logic [64:0] rsh;
  logic        take;
  logic [127:0] acc_add;

  assign rsh     = {rem, lo[63]};
  assign take    = rsh[64] || (rsh[63:0] >= d);
  assign acc_add = mplier[0] ? (acc + mcand) : acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      if (req.start) begin
        op  <= req.op;
        neg <= req.x[63] ^ req.y[63];
        cnt <= 7'd0;
        acc <= '0;
        q   <= '0;
        case (req.op)
          OP_DIV: begin
            if (mag(req.x) == 64'd0) begin
              rsp.res <= '0; rsp.done <= 1'b1;
            end else if (mag(req.y) == 64'd0) begin
              rsp.res <= mk(req.x[63], '1); rsp.done <= 1'b1;
            end else if ((mag(req.x) >> 32) >= mag(req.y)) begin
              rsp.res <= mk(req.x[63] ^ req.y[63], '1); rsp.done <= 1'b1;
            end else begin
              rem  <= mag(req.x) >> 32;
              lo   <= mag(req.x) << 32;
              d    <= mag(req.y);
              busy <= 1'b1;
            end
          end
          OP_ZMUL: begin
            mcand  <= {64'd0, mag(req.x)};
            mplier <= ZEPS2_Q64;
            busy   <= 1'b1;
          end
          default: begin
            mcand  <= {64'd0, mag(req.x)};
            mplier <= mag(req.y);
            busy   <= 1'b1;
          end
        endcase
      end else if (busy) begin
        cnt <= cnt + 7'd1;
        if (op == OP_DIV) begin
          lo <= lo << 1;
          q  <= {q[62:0], take};
          rem <= take ? (rsh[63:0] - d) : rsh[63:0];
          if (cnt == 7'd63) begin
            busy <= 1'b0; rsp.done <= 1'b1;
            rsp.res <= mk(neg, {q[62:0], take});
          end
        end else begin
          // shift-add, lsb of multiplier first
          acc    <= acc_add;
          mplier <= mplier >> 1;
          mcand  <= mcand << 1;
          if (cnt == 7'd63) begin
            busy <= 1'b0; rsp.done <= 1'b1;
            if (op == OP_ZMUL) rsp.res <= acc_add[127:64];
            else if (acc_add[127:96] != 32'd0) rsp.res <= mk(neg, '1);
            else rsp.res <= mk(neg, acc_add[95:32]);
          end
        end
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) req.start |=> !(busy && rsp.done))
    else $error("done raised while still busy");
  assert property (@(posedge clk) disable iff (rst) busy && cnt != 7'd63 |=> busy)
    else $error("unit stopped early");
  assert property (@(posedge clk) disable iff (rst) rsp.done |=> !rsp.done)
    else $error("done longer than one cycle");

endmodule

// File: src/brent_root_finder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brent_root_finder
// brent root finder, point-request engine in signed q31.32
// ----------------------------------------------------------------------------
// channel | signals                                          | dir
// in      | in_valid in_ready mode left_end right_end         | in
//         | function_value                                    |
// out     | out_valid out_ready status point                  | out
// cfg     | cfg_valid cfg_ready tolerance                     | in
//
// a start item or a first-value item answers in the cycle after it is taken;
// a brent step runs on the shared one-bit-per-cycle mul/div unit, with up
// to fourteen operations per step.
// reset (rst, synchronous) returns to idle with tolerance 4295.
// in_ready is low while a step runs and while a result waits in the output
// register; the output register holds until out_ready.
// ----------------------------------------------------------------------------
module brent_root_finder import brf_pkg::*; #(
  parameter int MAX_ITERATIONS = MAX_ITER_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        mode,
  input  logic [63:0] left_end,
  input  logic [63:0] right_end,
  input  logic [63:0] function_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [63:0] point,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [62:0] tolerance
);

  logic [62:0] tol;
  phase_t      phase;
  logic [6:0]  iter;
  seq_t        seq;
  logic [63:0] a, b, c, fa, fb, fc, dd, ee, tol1, xm, s, p, q, r, t, m1, tmp;

  unit_req_t ureq;
  unit_rsp_t ursp;

  brf_unit u_unit (.clk(clk), .rst(rst), .req(ureq), .rsp(ursp));

  assign cfg_ready = 1'b1;
  assign in_ready  = (seq == S_IDLE) && !out_valid;

  logic [63:0] xm2;
  logic [63:0] hd;
  assign xm2 = sadd(xm, xm);

  always_comb begin
    logic [63:0] m;
    m = b - c;
    if ($signed(c) >= $signed(b)) hd = (c - b) >> 1;
    else hd = mk(1'b1, (m >> 1) + {63'd0, m[0]});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tol       <= TOL_RESET;
      phase     <= PH_IDLE;
      seq       <= S_IDLE;
      iter      <= '0;
      out_valid <= 1'b0;
      ureq.start <= 1'b0;
      a <= '0; b <= '0; c <= '0; fa <= '0; fb <= '0; fc <= '0; dd <= '0; ee <= '0;
    end else begin
      ureq.start <= 1'b0;
      if (cfg_valid) tol <= tolerance;
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (seq)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            if (!mode) begin
              a <= left_end; b <= right_end; c <= right_end; iter <= '0;
              phase <= PH_LEFT;
              status <= ST_EVAL; point <= left_end; out_valid <= 1'b1;
            end else begin
              case (phase)
                PH_LEFT: begin
                  fa <= function_value; phase <= PH_RIGHT;
                  status <= ST_EVAL; point <= b; out_valid <= 1'b1;
                end
                PH_RIGHT: begin
                  fb <= function_value;
                  if (mag(fa) < {1'b0, tol}) begin
                    status <= ST_ROOT; point <= a; out_valid <= 1'b1; phase <= PH_IDLE;
                  end else if (mag(function_value) < {1'b0, tol}) begin
                    status <= ST_ROOT; point <= b; out_valid <= 1'b1; phase <= PH_IDLE;
                  end else if ((!fa[63] && fa != 0 && !function_value[63] &&
                                function_value != 0) || (fa[63] && function_value[63])) begin
                    status <= ST_NOSGN; point <= '0; out_valid <= 1'b1; phase <= PH_IDLE;
                  end else begin
                    fc <= function_value; iter <= 7'd1; seq <= S_PRE;
                  end
                end
                PH_ITER: begin
                  if (iter >= 7'(MAX_ITERATIONS)) begin
                    status <= ST_LIMIT; point <= b; out_valid <= 1'b1; phase <= PH_IDLE;
                  end else begin
                    fb <= function_value; iter <= iter + 7'd1; seq <= S_PRE;
                  end
                end
                default: ;  // value while idle is dropped
              endcase
            end
          end
        end
        S_PRE: begin
          // contrapoint update then swap so that b is best
          logic [63:0] nc, nfc, nd, ne;
          nc = c; nfc = fc; nd = dd; ne = ee;
          if ((!fb[63] && fb != 0 && !fc[63] && fc != 0) || (fb[63] && fc[63])) begin
            nc = a; nfc = fa; nd = ssub(b, a); ne = ssub(b, a);
          end
          dd <= nd; ee <= ne;
          if (mag(nfc) < mag(fb)) begin
            a <= b; b <= nc; c <= b; fa <= fb; fb <= nfc; fc <= fb;
          end else begin
            c <= nc; fc <= nfc;
          end
          seq <= S_TOL;
        end
        S_TOL: begin
          ureq.start <= 1'b1; ureq.op <= OP_ZMUL; ureq.x <= b; ureq.y <= '0;
          seq <= S_TOLW;
        end
        S_TOLW: if (ursp.done) begin
          tol1 <= ursp.res + {2'b0, tol[62:1]}; xm <= hd; seq <= S_CHK;
        end
        S_CHK: begin
          if (mag(xm) < tol1 || fb == 0) begin
            status <= ST_ROOT; point <= b; out_valid <= 1'b1; phase <= PH_IDLE;
            seq <= S_IDLE;
          end else if (mag(ee) >= tol1 && mag(fa) > mag(fb)) begin
            seq <= S_S;
          end else begin
            dd <= xm; ee <= xm; seq <= S_FIN;
          end
        end
        S_S: begin
          ureq.start <= 1'b1; ureq.op <= OP_DIV; ureq.x <= fb; ureq.y <= fa; seq <= S_SW;
        end
        S_SW: if (ursp.done) begin
          s <= ursp.res;
          if (a == c) begin
            q <= ssub(Q_ONE, ursp.res);
            ureq.start <= 1'b1; ureq.op <= OP_MUL; ureq.x <= xm2; ureq.y <= ursp.res;
            seq <= S_PW;
          end else seq <= S_Q;
        end
        S_Q: begin
          ureq.start <= 1'b1; ureq.op <= OP_DIV; ureq.x <= fa; ureq.y <= fc; seq <= S_QW;
        end
        S_QW: if (ursp.done) begin q <= ursp.res; seq <= S_R; end
        S_R: begin
          ureq.start <= 1'b1; ureq.op <= OP_DIV; ureq.x <= fb; ureq.y <= fc; seq <= S_RW;
        end
        S_RW: if (ursp.done) begin r <= ursp.res; seq <= S_T1; end
        S_T1: begin
          ureq.start <= 1'b1; ureq.op <= OP_MUL; ureq.x <= xm2; ureq.y <= q; seq <= S_T1W;
        end
        S_T1W: if (ursp.done) begin tmp <= ursp.res; seq <= S_T2; end
        S_T2: begin
          ureq.start <= 1'b1; ureq.op <= OP_MUL; ureq.x <= tmp; ureq.y <= ssub(q, r);
          seq <= S_T2W;
        end
        S_T2W: if (ursp.done) begin t <= ursp.res; seq <= S_T3; end
        S_T3: begin
          ureq.start <= 1'b1; ureq.op <= OP_MUL; ureq.x <= ssub(b, a);
          ureq.y <= ssub(r, Q_ONE); seq <= S_T3W;
        end
        S_T3W: if (ursp.done) begin t <= ssub(t, ursp.res); seq <= S_P; end
        S_P: begin
          ureq.start <= 1'b1; ureq.op <= OP_MUL; ureq.x <= s; ureq.y <= t; seq <= S_Q1;
        end
        S_Q1: if (ursp.done) begin
          p <= ursp.res;
          ureq.start <= 1'b1; ureq.op <= OP_MUL; ureq.x <= ssub(q, Q_ONE);
          ureq.y <= ssub(r, Q_ONE); seq <= S_Q1W;
        end
        S_Q1W: if (ursp.done) begin tmp <= ursp.res; seq <= S_Q2; end
        S_Q2: begin
          ureq.start <= 1'b1; ureq.op <= OP_MUL; ureq.x <= tmp; ureq.y <= ssub(s, Q_ONE);
          seq <= S_Q2W;
        end
        S_Q2W: if (ursp.done) begin
          if (!p[63] && p != 0) q <= sneg(ursp.res); else q <= ursp.res;
          p <= sabs(p); seq <= S_M1;
        end
        S_PW: if (ursp.done) begin
          // secant branch: p from unit, q already set
          if (!ursp.res[63] && ursp.res != 0) q <= sneg(q);
          p <= sabs(ursp.res); seq <= S_M1;
        end
        S_M1: begin
          ureq.start <= 1'b1; ureq.op <= OP_MUL; ureq.x <= sadd(xm2, xm); ureq.y <= q;
          seq <= S_M1W;
        end
        S_M1W: if (ursp.done) begin m1 <= ursp.res; seq <= S_M2; end
        S_M2: begin
          ureq.start <= 1'b1; ureq.op <= OP_MUL; ureq.x <= tol1; ureq.y <= q; seq <= S_M2W;
        end
        S_M2W: if (ursp.done) begin m1 <= ssub(m1, sabs(ursp.res)); seq <= S_M3; end
        S_M3: begin
          ureq.start <= 1'b1; ureq.op <= OP_MUL; ureq.x <= ee; ureq.y <= q; seq <= S_M3W;
        end
        S_M3W: if (ursp.done) begin
          if ($signed(sadd(p, p)) <
              ($signed(m1) < $signed(sabs(ursp.res)) ? $signed(m1) : $signed(sabs(ursp.res))))
            seq <= S_DIV;
          else begin
            dd <= xm; ee <= xm; seq <= S_FIN;
          end
        end
        S_DIV: begin
          ee <= dd;
          ureq.start <= 1'b1; ureq.op <= OP_DIV; ureq.x <= p; ureq.y <= q; seq <= S_DIVW;
        end
        S_DIVW: if (ursp.done) begin dd <= ursp.res; seq <= S_FIN; end
        S_FIN: begin
          logic [63:0] nb;
          if (mag(dd) > tol1) nb = sadd(b, dd);
          else nb = sadd(b, xm[63] ? (64'd0 - tol1) : tol1);
          a <= b; fa <= fb; b <= nb;
          phase <= PH_ITER;
          status <= ST_EVAL; point <= nb; out_valid <= 1'b1;
          seq <= S_IDLE;
        end
        default: seq <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) out_valid && !out_ready |=> out_valid)
    else $error("result dropped before taken");
  assert property (@(posedge clk) disable iff (rst) (seq != S_IDLE) |-> !in_ready)
    else $error("ready during a step");
  assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_EVAL && !$past(out_valid) |-> phase == PH_IDLE)
    else $error("terminal result left search running");

endmodule
